[src/qdd_pkg.sv]
// Shared types, codes and lookup functions for the quadrature detent decoder.
package qdd_pkg;

    // Configuration register indexes
    localparam logic CFG_STEPS_PER_DETENT = 1'b0;
    localparam logic CFG_FAST_THRESHOLD   = 1'b1;

    localparam int CFG_DATA_W = 8;

    // Register reset values
    localparam logic [3:0] STEPS_RESET  = 4'd4;
    localparam logic [7:0] THRESH_RESET = 8'd150;

    // Detent event codes
    localparam logic [1:0] DET_NONE = 2'd0;
    localparam logic [1:0] DET_UP   = 2'd1;
    localparam logic [1:0] DET_DOWN = 2'd2;

    // Button event codes (two's complement)
    localparam logic signed [1:0] BTN_NONE    = 2'sd0;
    localparam logic signed [1:0] BTN_PRESS   = 2'sd1;
    localparam logic signed [1:0] BTN_RELEASE = -2'sd1;

    // Tick counter ceiling
    localparam logic [7:0] TICK_MAX = 8'hff;

    // One result word
    typedef struct packed {
        logic signed [1:0] button_event;
        logic [1:0]        detent_event;
        logic              detent_fast;
        logic signed [7:0] step_count;
    } t_result;

    // Quadrature step from previous AB (upper bits) and current AB (lower bits)
    function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        unique case (idx) inside
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            4'd1, 4'd7, 4'd8, 4'd14:  d = -2'sd1;
            default:                  d = 2'sd0;
        endcase
        return d;
    endfunction

    // Button edge from a three-sample history, newest in bit 0
    function automatic logic signed [1:0] btn_edge(input logic [2:0] hist);
        logic signed [1:0] e;
        unique case (hist)
            3'b011:  e = BTN_PRESS;
            3'b100:  e = BTN_RELEASE;
            default: e = BTN_NONE;
        endcase
        return e;
    endfunction

endpackage

[src/qdd_if.sv]
// Handshake interfaces for the sample, result and configuration channels.
interface qdd_in_if;
    logic valid;
    logic ready;
    logic pin_a;
    logic pin_b;
    logic button_pin;

    modport source (output valid, output pin_a, output pin_b, output button_pin,
                    input ready);
    modport sink   (input valid, input pin_a, input pin_b, input button_pin,
                    output ready);
endinterface

interface qdd_out_if;
    logic              valid;
    logic              ready;
    logic signed [1:0] button_event;
    logic [1:0]        detent_event;
    logic              detent_fast;
    logic signed [7:0] step_count;

    modport source (output valid, output button_event, output detent_event,
                    output detent_fast, output step_count, input ready);
    modport sink   (input valid, input button_event, input detent_event,
                    input detent_fast, input step_count, output ready);
endinterface

interface qdd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic                          index;
    logic [qdd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/quadrature_detent_decoder.sv]
// Quadrature encoder decoder with detent events and button edge detection.
//
// Channels: i_in carries one sample word per tick (pin_a, pin_b, button_pin);
// o_out returns exactly one result word per sample (button_event,
// detent_event, detent_fast, step_count). i_cfg writes steps_per_detent
// (index 0, low four bits) and fast_threshold (index 1); it is always ready
// and should be used only while no sample is in flight.
// Each sample's result is registered into the result register, or into the skid
// register while that one waits. Throughput: one sample per cycle while i_in.ready
// is high; all decode work is a single short pass from the sample port into the buffer.
// Stalls: a two-entry output buffer (result register plus skid register)
// lets one more sample in while a result waits; i_in.ready drops only when
// both entries are full, and rises again as soon as o_out takes a word.
// Reset (synchronous, active low) clears the encoder history, button history,
// step accumulator, tick counter and both output entries, and restores the
// registers to four steps per detent and a fast threshold of 150.
module quadrature_detent_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qdd_in_if.sink     i_in,
    qdd_out_if.source  o_out,
    qdd_cfg_if.sink    i_cfg
);

    // Configuration
    logic [3:0] r_steps;
    logic [7:0] r_thresh;

    // Decode state
    logic [1:0]        r_last_ab;
    logic [2:0]        r_hist;
    logic signed [7:0] r_accum;
    logic [7:0]        r_tick;

    // Output buffer
    qdd_pkg::t_result r_out;
    qdd_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;

    // Next values
    logic [1:0]        n_last_ab;
    logic [2:0]        n_hist;
    logic signed [7:0] n_accum;
    logic [7:0]        n_tick;
    qdd_pkg::t_result  n_result;

    logic              in_fire;
    logic              out_fire;
    logic              cfg_fire;
    logic signed [1:0] delta;
    logic signed [8:0] sum;
    logic signed [7:0] acc_sat;
    logic [7:0]        tick_inc;
    logic [3:0]        spd;
    logic signed [7:0] spd_s;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_out_valid && o_out.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;

    assign i_in.ready  = !r_skid_valid;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.button_event = r_out.button_event;
    assign o_out.detent_event = r_out.detent_event;
    assign o_out.detent_fast  = r_out.detent_fast;
    assign o_out.step_count   = r_out.step_count;

    // Decode one sample: button edge, quadrature step, tick count, detent check
    always_comb begin
        n_last_ab = {i_in.pin_a, i_in.pin_b};
        n_hist    = {r_hist[1:0], i_in.button_pin};
        delta     = qdd_pkg::quad_delta({r_last_ab, n_last_ab});
        sum       = 9'(r_accum) + 9'(delta);
        if (sum > 9'sd127) begin
            acc_sat = 8'sd127;
        end else if (sum < -9'sd128) begin
            acc_sat = -8'sd128;
        end else begin
            acc_sat = sum[7:0];
        end
        tick_inc = (r_tick == qdd_pkg::TICK_MAX) ? r_tick : r_tick + 8'd1;
        spd      = (r_steps == 4'd0) ? 4'd1 : r_steps;
        spd_s    = signed'({4'b0000, spd});

        n_result.button_event = qdd_pkg::btn_edge(n_hist);
        n_result.detent_event = qdd_pkg::DET_NONE;
        n_result.detent_fast  = 1'b0;
        n_accum = acc_sat;
        n_tick  = tick_inc;
        if (acc_sat >= spd_s) begin
            n_accum               = acc_sat - spd_s;
            n_result.detent_event = qdd_pkg::DET_UP;
        end else if (acc_sat <= -spd_s) begin
            n_accum               = acc_sat + spd_s;
            n_result.detent_event = qdd_pkg::DET_DOWN;
        end
        if (n_result.detent_event != qdd_pkg::DET_NONE) begin
            n_result.detent_fast = (tick_inc < r_thresh);
            n_tick               = 8'd0;
        end
        n_result.step_count = n_accum;
    end

    // Hold configuration; write on a configuration handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps  <= qdd_pkg::STEPS_RESET;
            r_thresh <= qdd_pkg::THRESH_RESET;
        end else if (cfg_fire) begin
            unique case (i_cfg.index)
                qdd_pkg::CFG_STEPS_PER_DETENT: r_steps  <= i_cfg.data[3:0];
                qdd_pkg::CFG_FAST_THRESHOLD:   r_thresh <= i_cfg.data;
                default:                       r_steps  <= r_steps;
            endcase
        end
    end

    // Advance decode state on each accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ab <= 2'b00;
            r_hist    <= 3'b000;
            r_accum   <= 8'sd0;
            r_tick    <= 8'd0;
        end else if (in_fire) begin
            r_last_ab <= n_last_ab;
            r_hist    <= n_hist;
            r_accum   <= n_accum;
            r_tick    <= n_tick;
        end
    end

    // Output buffer control: refill the result register from skid or new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output buffer payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= n_result;
            end
        end else if (in_fire) begin
            r_skid <= n_result;
        end
    end

endmodule

[src/qdd_checker.sv]
// Port-level checks for the quadrature detent decoder, bound to the top level.
module qdd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_button_event,
    input logic [1:0] i_detent_event,
    input logic       i_detent_fast,
    input logic [7:0] i_step_count
);

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word withdrawn while stalled");

    // Fast flag only accompanies a detent
    a_fast_needs_detent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_detent_fast |-> i_detent_event != qdd_pkg::DET_NONE)
        else $error("fast flag without detent");

    // After a detent the accumulator sits on the near side of zero
    a_detent_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_detent_event != qdd_pkg::DET_UP || !i_step_count[7]) &&
            (i_detent_event != qdd_pkg::DET_DOWN || i_step_count[7] ||
             i_step_count == 8'd0))
        else $error("accumulator residue has wrong sign after detent");

    // Event fields carry only defined codes
    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_detent_event != 2'd3 && i_button_event != 2'b10)
        else $error("undefined event code");

endmodule

bind quadrature_detent_decoder qdd_checker u_qdd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_button_event (o_out.button_event),
    .i_detent_event (o_out.detent_event),
    .i_detent_fast  (o_out.detent_fast),
    .i_step_count   (o_out.step_count)
);

[tb/testbench.sv]
// Self-checking testbench for the quadrature detent decoder.
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 70;
    localparam int MAX_PRINTS  = 20;

    logic i_clk;
    logic i_rst_n;

    qdd_in_if  in_if ();
    qdd_out_if out_if ();
    qdd_cfg_if cfg_if ();

    quadrature_detent_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Decoder mirror: registers and state
    logic [3:0] cfg_steps  = qdd_pkg::STEPS_RESET;
    logic [7:0] cfg_thresh = qdd_pkg::THRESH_RESET;
    logic [1:0] m_last_ab  = '0;
    logic [2:0] m_btn_hist = '0;
    int         m_steps    = 0;
    logic [7:0] m_ticks    = '0;

    // Words predicted but not yet returned by the block
    qdd_pkg::t_result tick_results_q[$];

    // Idle control shared between the sender, the receiver and the tests
    bit src_idle = 1'b1;
    bit snk_idle = 1'b1;
    int hold_req = 0;

    // Stimulus walk state
    int   enc_pos = 0;
    int   enc_dir = 1;
    logic btn_lvl = 1'b0;

    // Tallies
    int n_errors   = 0;
    int n_samples  = 0;
    int n_results  = 0;
    int n_settings = 0;
    int n_up       = 0;
    int n_down     = 0;
    int n_fast     = 0;
    int n_press    = 0;
    int n_release  = 0;
    int n_holds    = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d words outstanding",
                 CYCLE_LIMIT, tick_results_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Log one mismatch and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("ERROR t=%0t word %0d: %s got %0d want %0d",
                     $time, n_results, what, got, want);
    endtask

    // Advance the decoder mirror by one sample and return the word it yields
    function automatic qdd_pkg::t_result decode_tick(input logic a, input logic b,
                                                     input logic btn);
        qdd_pkg::t_result r;
        logic [1:0]       was_pos;
        logic [1:0]       now_pos;
        logic [1:0]       diff;
        int               spd;
        r = '0;

        // Button edges from the last three samples
        m_btn_hist = {m_btn_hist[1:0], btn};
        if (m_btn_hist == 3'b011) begin
            r.button_event = qdd_pkg::BTN_PRESS;
            n_press++;
        end else if (m_btn_hist == 3'b100) begin
            r.button_event = qdd_pkg::BTN_RELEASE;
            n_release++;
        end else begin
            r.button_event = qdd_pkg::BTN_NONE;
        end

        // Position along the Gray cycle 00, 10, 11, 01; one place on is a step
        was_pos = {m_last_ab[0], m_last_ab[1] ^ m_last_ab[0]};
        now_pos = {b, a ^ b};
        diff    = now_pos - was_pos;
        if (diff == 2'd1)
            m_steps++;
        else if (diff == 2'd3)
            m_steps--;
        if (m_steps > 127)
            m_steps = 127;
        if (m_steps < -128)
            m_steps = -128;
        m_last_ab = {a, b};

        if (m_ticks != qdd_pkg::TICK_MAX)
            m_ticks++;

        // Detent: pull the accumulator back toward zero
        spd = (cfg_steps == 4'd0) ? 1 : int'(cfg_steps);
        if (m_steps >= spd) begin
            m_steps -= spd;
            r.detent_event = qdd_pkg::DET_UP;
            n_up++;
        end else if (m_steps <= -spd) begin
            m_steps += spd;
            r.detent_event = qdd_pkg::DET_DOWN;
            n_down++;
        end else begin
            r.detent_event = qdd_pkg::DET_NONE;
        end
        if (r.detent_event != qdd_pkg::DET_NONE) begin
            r.detent_fast = (m_ticks < cfg_thresh);
            if (r.detent_fast)
                n_fast++;
            m_ticks = '0;
        end

        r.step_count = m_steps[7:0];
        return r;
    endfunction

    // Offer one sample word and hold it until the block takes it
    task automatic send_sample(input logic a, input logic b, input logic btn);
        int gap;
        gap = src_idle ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
        end
        @(negedge i_clk);
        in_if.valid      = 1'b1;
        in_if.pin_a      = a;
        in_if.pin_b      = b;
        in_if.button_pin = btn;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        tick_results_q.push_back(decode_tick(a, b, btn));
        n_samples++;
    endtask

    // Send the AB pair for a place on the Gray cycle
    task automatic send_position(input int p, input logic btn);
        int q;
        q = p & 3;
        send_sample(q == 1 || q == 2, q >= 2, btn);
    endtask

    // Drop the sample valid and wait until every word has come back
    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (tick_results_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write one register; the block must be idle
    task automatic cfg_write(input logic idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        if (idx == qdd_pkg::CFG_STEPS_PER_DETENT)
            cfg_steps = val[3:0];
        else
            cfg_thresh = val;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_registers(input logic [7:0] steps_word, input logic [7:0] thresh);
        drain();
        cfg_write(qdd_pkg::CFG_STEPS_PER_DETENT, steps_word);
        cfg_write(qdd_pkg::CFG_FAST_THRESHOLD, thresh);
        n_settings++;
    endtask

    // One sample of a turning knob: mostly clean steps, some bounce and bad jumps
    task automatic send_motion();
        int r;
        if ($urandom_range(0, 99) < 8)
            enc_dir = -enc_dir;
        r = $urandom_range(0, 99);
        if (r < 65)
            enc_pos += enc_dir;
        else if (r < 75)
            enc_pos -= enc_dir;
        else if (r < 82)
            enc_pos += 2;
        if ($urandom_range(0, 7) == 0)
            btn_lvl = ~btn_lvl;
        send_position(enc_pos, btn_lvl);
    endtask

    // Receiver: stall at random, take each word, compare with the oldest prediction
    initial begin : result_checker
        int               gap;
        qdd_pkg::t_result want;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = snk_idle ? $urandom_range(0, 8) : 0;
            if (hold_req > 0) begin
                gap = hold_req;
                hold_req = 0;
                n_holds++;
            end
            repeat (gap) begin
                @(negedge i_clk);
                out_if.ready = 1'b0;
            end
            @(negedge i_clk);
            out_if.ready = 1'b1;
            @(posedge i_clk);
            while (!out_if.valid)
                @(posedge i_clk);
            n_results++;
            if (tick_results_q.size() == 0) begin
                report_mismatch("unexpected word, step_count", int'(out_if.step_count), 0);
            end else begin
                want = tick_results_q.pop_front();
                if (out_if.button_event !== want.button_event)
                    report_mismatch("button_event", int'(out_if.button_event),
                                    int'(want.button_event));
                if (out_if.detent_event !== want.detent_event)
                    report_mismatch("detent_event", int'(out_if.detent_event),
                                    int'(want.detent_event));
                if (out_if.detent_fast !== want.detent_fast)
                    report_mismatch("detent_fast", int'(out_if.detent_fast),
                                    int'(want.detent_fast));
                if (out_if.step_count !== want.step_count)
                    report_mismatch("step_count", int'(out_if.step_count),
                                    int'(want.step_count));
            end
        end
    end

    // Hand-picked sequences: both directions, button edges, bad jumps, register extremes
    task automatic test_directed();
        // Reset values: one full forward detent with a press, then one back with a release
        send_position(0, 1'b0);
        send_position(1, 1'b0);
        send_position(2, 1'b1);
        send_position(3, 1'b1);
        send_position(0, 1'b1);
        send_position(3, 1'b1);
        send_position(2, 1'b0);
        send_position(1, 1'b0);
        send_position(0, 1'b0);
        // Diagonal jumps count as no step
        send_position(2, 1'b1);
        send_position(0, 1'b0);
        send_position(2, 1'b1);
        // Zero steps per detent acts as one; a zero threshold is never fast
        set_registers(8'hF0, 8'h00);
        send_position(1, 1'b1);
        send_position(2, 1'b1);
        send_position(1, 1'b0);
        send_position(0, 1'b0);
        // Largest step count and threshold
        set_registers(8'h0F, 8'hFF);
        send_position(3, 1'b1);
        send_position(2, 1'b1);
        send_position(1, 1'b0);
        send_position(0, 1'b0);
        enc_pos = 0;
    endtask

    // Long random turning across several register settings and idle mixes
    task automatic test_random_turning();
        int k;
        int i;
        int still;
        logic [7:0] steps_word;
        logic [7:0] thresh;
        for (k = 0; k < 8; k++) begin
            case (k)
                0: begin steps_word = 8'h04; thresh = 8'd150; end
                1: begin steps_word = 8'h01; thresh = 8'd0;   end
                2: begin steps_word = 8'h0F; thresh = 8'd255; end
                3: begin steps_word = 8'h08; thresh = 8'd10;  end
                4: begin steps_word = 8'h30; thresh = 8'd255; end
                5: begin
                    steps_word = {4'($urandom), 4'($urandom_range(1, 8))};
                    thresh     = 8'($urandom);
                end
                6: begin steps_word = 8'($urandom); thresh = 8'($urandom); end
                default: begin steps_word = 8'h02; thresh = 8'd40; end
            endcase
            set_registers(steps_word, thresh);
            src_idle = (k % 4 == 0) || (k % 4 == 1);
            snk_idle = (k % 4 == 0) || (k % 4 == 2);
            i = 0;
            while (i < PHASE_ITEMS) begin
                // Now and then the knob rests so slow detents occur
                if ($urandom_range(0, 29) == 0) begin
                    still = $urandom_range(3, 50);
                    repeat (still) send_position(enc_pos, btn_lvl);
                    i += still;
                end else begin
                    send_motion();
                    i++;
                end
            end
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    // Rest long enough for the tick counter to stick at its ceiling
    task automatic test_tick_saturation();
        set_registers(8'h02, 8'd255);
        repeat (300) send_position(enc_pos, 1'b0);
        send_position(enc_pos + 1, 1'b0);
        send_position(enc_pos + 2, 1'b0);
        enc_pos += 2;
        set_registers(8'h03, 8'd254);
        repeat (270) send_position(enc_pos, 1'b1);
        repeat (3) begin
            enc_pos--;
            send_position(enc_pos, 1'b1);
        end
    endtask

    // Hold the output off for a long stretch while samples keep coming
    task automatic test_backpressure();
        set_registers(8'h01, 8'd100);
        src_idle = 1'b0;
        snk_idle = 1'b0;
        hold_req = 40;
        repeat (30) send_motion();
        hold_req = 25;
        repeat (30) send_motion();
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    // Stop sending until every word is back, then carry on
    task automatic test_sender_pause();
        repeat (20) send_motion();
        drain();
        src_idle = 1'b0;
        repeat (20) send_motion();
        src_idle = 1'b1;
    endtask

    // Sequence of tests
    initial begin
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.pin_a      = 1'b0;
        in_if.pin_b      = 1'b0;
        in_if.button_pin = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = qdd_pkg::CFG_STEPS_PER_DETENT;
        cfg_if.data      = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_turning();
        test_tick_saturation();
        test_backpressure();
        test_sender_pause();

        drain();
        repeat (4) @(posedge i_clk);
        $display("Ran %0d samples over %0d register settings, %0d output hold-offs",
                 n_samples, n_settings, n_holds);
        $display("Saw %0d up / %0d down detents (%0d fast), %0d presses, %0d releases",
                 n_up, n_down, n_fast, n_press, n_release);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
